// ----- rtl/hwu_pkg.sv -----
// Shared types, constants and a helper function for the Hebbian weight update block.
`timescale 1ns / 1ps

package hwu_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned GAIN_W   = 7;
    localparam int unsigned GAINS_W  = 4 * GAIN_W;
    localparam int unsigned FACTOR_W = 26;
    localparam int unsigned PROD_W   = (DATA_W - 1) + GAIN_W;
    localparam int unsigned PLO_W    = PROD_W / 2;
    localparam int unsigned PHI_W    = PROD_W - PLO_W;
    localparam int unsigned PART_W   = PHI_W + FACTOR_W;
    localparam int unsigned FULL_W   = 64;
    localparam int unsigned IDX_W    = 3;

    localparam logic [GAINS_W-1:0] GAINS_RESET   = 28'd52841675;
    localparam logic [DATA_W-1:0]  CEILING_RESET = 32'd65536;

    typedef enum logic [IDX_W-1:0] {
        REG_FACTOR_SELECT = 3'd0,
        REG_QUADRANT_GAINS = 3'd1,
        REG_PRE_THRESHOLD = 3'd2,
        REG_POST_TH_PRE_HIGH = 3'd3,
        REG_POST_TH_PRE_LOW = 3'd4,
        REG_WEIGHT_FLOOR = 3'd5,
        REG_WEIGHT_CEILING = 3'd6,
        REG_MODE_BITS = 3'd7
    } cfg_idx_e;

    typedef enum logic [1:0] {
        QUAD_PRE_HI_POST_HI = 2'd0,
        QUAD_PRE_HI_POST_LO = 2'd1,
        QUAD_PRE_LO_POST_HI = 2'd2,
        QUAD_PRE_LO_POST_LO = 2'd3
    } quad_e;

    typedef struct packed {
        logic [1:0]               factor_select;
        logic [GAINS_W-1:0]       quadrant_gains;
        logic signed [DATA_W-1:0] pre_threshold;
        logic signed [DATA_W-1:0] post_th_pre_high;
        logic signed [DATA_W-1:0] post_th_pre_low;
        logic signed [DATA_W-1:0] weight_floor;
        logic signed [DATA_W-1:0] weight_ceiling;
        logic                     mode_volt;
        logic                     mode_prev;
    } cfg_t;

    // classified connection, leaving stage 1
    typedef struct packed {
        logic signed [DATA_W-1:0] weight;
        logic [GAIN_W-1:0]        gain;
        logic                     eligible;
        logic                     raise;
    } cls_t;

    // scaled connection, leaving the multiplier stages
    typedef struct packed {
        logic signed [DATA_W-1:0] weight;
        logic [DATA_W-1:0]        change;
        logic                     eligible;
        logic                     raise;
    } scl_t;

    // Q0.32 scale factors, rounded to nearest
    function automatic logic [FACTOR_W-1:0] factor_q32(input logic [1:0] sel);
        logic [FACTOR_W-1:0] f;
        unique case (sel)
            2'd0: f = 26'd42949673;
            2'd1: f = 26'd4294967;
            2'd2: f = 26'd429497;
            2'd3: f = 26'd42950;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/hwu_cfg.sv -----
// Configuration register file for the Hebbian weight update block.
`timescale 1ns / 1ps

module hwu_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [hwu_pkg::IDX_W-1:0]    cfg_addr,
    input  logic [hwu_pkg::DATA_W-1:0]   cfg_wdata,
    output hwu_pkg::cfg_t                cfg
);
    import hwu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_e'(cfg_addr))
                REG_FACTOR_SELECT:    cfg_next.factor_select    = cfg_wdata[1:0];
                REG_QUADRANT_GAINS:   cfg_next.quadrant_gains   = cfg_wdata[GAINS_W-1:0];
                REG_PRE_THRESHOLD:    cfg_next.pre_threshold    = cfg_wdata;
                REG_POST_TH_PRE_HIGH: cfg_next.post_th_pre_high = cfg_wdata;
                REG_POST_TH_PRE_LOW:  cfg_next.post_th_pre_low  = cfg_wdata;
                REG_WEIGHT_FLOOR:     cfg_next.weight_floor     = cfg_wdata;
                REG_WEIGHT_CEILING:   cfg_next.weight_ceiling   = cfg_wdata;
                REG_MODE_BITS: begin
                    cfg_next.mode_volt = cfg_wdata[0];
                    cfg_next.mode_prev = cfg_wdata[1];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.factor_select    <= 2'd0;
            cfg_reg.quadrant_gains   <= GAINS_RESET;
            cfg_reg.pre_threshold    <= '0;
            cfg_reg.post_th_pre_high <= '0;
            cfg_reg.post_th_pre_low  <= '0;
            cfg_reg.weight_floor     <= '0;
            cfg_reg.weight_ceiling   <= CEILING_RESET;
            cfg_reg.mode_volt        <= 1'b0;
            cfg_reg.mode_prev        <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/hwu_classify.sv -----
// Stage 1: eligibility check, quadrant decision and gain pick.
`timescale 1ns / 1ps

module hwu_classify (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hwu_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [hwu_pkg::DATA_W-1:0] weight_in,
    input  logic signed [hwu_pkg::DATA_W-1:0] pre_rate_now,
    input  logic signed [hwu_pkg::DATA_W-1:0] pre_rate_prev,
    input  logic signed [hwu_pkg::DATA_W-1:0] post_rate,
    input  logic signed [hwu_pkg::DATA_W-1:0] post_voltage,
    input  logic                              is_plastic,
    output logic                              out_valid,
    input  logic                              out_ready,
    output hwu_pkg::cls_t                     out_data
);
    import hwu_pkg::*;

    logic valid_reg;
    cls_t data_reg;
    cls_t data_next;

    logic signed [DATA_W-1:0] pre;
    logic signed [DATA_W-1:0] post;
    logic signed [DATA_W-1:0] th_hi;
    logic signed [DATA_W-1:0] th_lo;
    quad_e                    quad;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        pre   = cfg.mode_prev ? pre_rate_prev : pre_rate_now;
        post  = cfg.mode_volt ? post_voltage : post_rate;
        th_hi = cfg.mode_volt ? cfg.post_th_pre_high : cfg.pre_threshold;
        th_lo = cfg.mode_volt ? cfg.post_th_pre_low : cfg.pre_threshold;

        if (pre >= cfg.pre_threshold) begin
            quad = (post >= th_hi) ? QUAD_PRE_HI_POST_HI : QUAD_PRE_HI_POST_LO;
        end else begin
            quad = (post >= th_lo) ? QUAD_PRE_LO_POST_HI : QUAD_PRE_LO_POST_LO;
        end

        data_next.weight   = weight_in;
        data_next.eligible = (weight_in > 0) && (weight_in >= cfg.weight_floor)
                             && (weight_in <= cfg.weight_ceiling) && is_plastic;
        data_next.raise    = (quad == QUAD_PRE_HI_POST_HI);
        unique case (quad)
            QUAD_PRE_HI_POST_HI: data_next.gain = cfg.quadrant_gains[0*GAIN_W +: GAIN_W];
            QUAD_PRE_HI_POST_LO: data_next.gain = cfg.quadrant_gains[1*GAIN_W +: GAIN_W];
            QUAD_PRE_LO_POST_HI: data_next.gain = cfg.quadrant_gains[2*GAIN_W +: GAIN_W];
            QUAD_PRE_LO_POST_LO: data_next.gain = cfg.quadrant_gains[3*GAIN_W +: GAIN_W];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/hwu_scale.sv -----
// Stages 2-4: weight*gain, split multiply by the Q0.32 factor, recombine and truncate.
`timescale 1ns / 1ps

module hwu_scale (
    input  logic          aclk,
    input  logic          aresetn,
    input  hwu_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  hwu_pkg::cls_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output hwu_pkg::scl_t out_data
);
    import hwu_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] weight;
        logic                     eligible;
        logic                     raise;
    } side_t;

    // stage 2
    logic              v2_reg;
    side_t             side2_reg;
    logic [PROD_W-1:0] prod_reg;
    // stage 3
    logic              v3_reg;
    side_t             side3_reg;
    logic [PART_W-1:0] part_lo_reg;
    logic [PART_W-1:0] part_hi_reg;
    // stage 4
    logic              v4_reg;
    side_t             side4_reg;
    logic [DATA_W-1:0] change_reg;

    logic              rdy2;
    logic              rdy3;
    logic              rdy4;
    logic [FACTOR_W-1:0] factor;
    logic [FULL_W-1:0] full_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    assign factor = factor_q32(cfg.factor_select);

    // weight is positive whenever the product matters, so its sign bit is dropped
    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            prod_reg  <= PROD_W'(in_data.weight[DATA_W-2:0]) * PROD_W'(in_data.gain);
            side2_reg <= '{in_data.weight, in_data.eligible, in_data.raise};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            part_lo_reg <= PART_W'(prod_reg[PLO_W-1:0]) * PART_W'(factor);
            part_hi_reg <= PART_W'(prod_reg[PROD_W-1:PLO_W]) * PART_W'(factor);
            side3_reg   <= side2_reg;
        end
    end

    assign full_next = (FULL_W'(part_hi_reg) << PLO_W) + FULL_W'(part_lo_reg);

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            change_reg <= full_next[FULL_W-1:FULL_W-DATA_W];
            side4_reg  <= side3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy2) v2_reg <= in_valid;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    assign out_valid         = v4_reg;
    assign out_data.weight   = side4_reg.weight;
    assign out_data.change   = change_reg;
    assign out_data.eligible = side4_reg.eligible;
    assign out_data.raise    = side4_reg.raise;

endmodule

// ----- rtl/hwu_clamp.sv -----
// Stage 5: apply the change with range and zero clamps, output register.
`timescale 1ns / 1ps

module hwu_clamp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hwu_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hwu_pkg::scl_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [hwu_pkg::DATA_W-1:0]  weight_out,
    output logic                               was_changed
);
    import hwu_pkg::*;

    logic                     valid_reg;
    logic signed [DATA_W-1:0] weight_reg;
    logic                     changed_reg;
    logic signed [DATA_W-1:0] weight_next;

    logic signed [DATA_W:0] w_ext;
    logic signed [DATA_W:0] chg_ext;
    logic signed [DATA_W:0] room_up;
    logic signed [DATA_W:0] room_down;
    logic signed [DATA_W:0] sum_up;
    logic signed [DATA_W:0] sum_down;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        w_ext     = {in_data.weight[DATA_W-1], in_data.weight};
        chg_ext   = {1'b0, in_data.change};
        room_up   = {cfg.weight_ceiling[DATA_W-1], cfg.weight_ceiling} - w_ext;
        room_down = w_ext - {cfg.weight_floor[DATA_W-1], cfg.weight_floor};
        sum_up    = w_ext + chg_ext;
        sum_down  = w_ext - chg_ext;

        if (!in_data.eligible) begin
            weight_next = in_data.weight;
        end else if (in_data.raise) begin
            weight_next = (chg_ext < room_up) ? sum_up[DATA_W-1:0] : cfg.weight_ceiling;
        end else if (chg_ext < room_down) begin
            weight_next = sum_down[DATA_W] ? '0 : sum_down[DATA_W-1:0];
        end else begin
            weight_next = cfg.weight_floor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            weight_reg  <= weight_next;
            changed_reg <= in_data.eligible;
        end
    end

    assign out_valid   = valid_reg;
    assign weight_out  = weight_reg;
    assign was_changed = changed_reg;

endmodule

// ----- rtl/hebbian_weight_update.sv -----
// Top level of the four-quadrant Hebbian weight update pipeline.
//
//  channel   dir  handshake             payload
//  s_        in   s_tvalid / s_tready   tdata: connection operands, tuser: plastic flag
//  m_        out  m_tvalid / m_tready   tdata: new weight, tuser: changed flag
//  cfg_      in   cfg_wr_en             cfg_addr register index, cfg_wdata value
//
//  One transaction per cycle sustained while m_tready stays high; the five
//  register stages from input acceptance to m_tvalid are: classify,
//  weight*gain, split factor multiply, recombine, clamp/output.
//  aresetn is synchronous, active low; it empties the pipeline and loads the
//  register defaults. A stall on m_tready backs up stage by stage; an empty
//  stage still accepts, so no transaction is dropped or duplicated.
`timescale 1ns / 1ps

module hebbian_weight_update (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write port
    input  logic                       cfg_wr_en,
    input  logic [hwu_pkg::IDX_W-1:0]  cfg_addr,
    input  logic [hwu_pkg::DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // weight_in, pre_rate_now, pre_rate_prev, post_rate, post_voltage (32 bits each)
    input  logic [159:0]               s_tdata,
    // is_plastic
    input  logic                       s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // weight_out
    output logic [31:0]                m_tdata,
    // was_changed
    output logic                       m_tuser
);
    import hwu_pkg::*;

    cfg_t cfg;

    logic cls_valid;
    logic cls_ready;
    cls_t cls_data;

    logic scl_valid;
    logic scl_ready;
    scl_t scl_data;

    logic signed [DATA_W-1:0] weight_out;

    // register file; write it only while the pipeline is idle
    hwu_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // stage 1: eligibility and quadrant -> gain
    hwu_classify u_classify (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .weight_in     (s_tdata[31:0]),
        .pre_rate_now  (s_tdata[63:32]),
        .pre_rate_prev (s_tdata[95:64]),
        .post_rate     (s_tdata[127:96]),
        .post_voltage  (s_tdata[159:128]),
        .is_plastic    (s_tuser),
        .out_valid     (cls_valid),
        .out_ready     (cls_ready),
        .out_data      (cls_data)
    );

    // stages 2-4: change = (weight * gain * factor) >> 32
    hwu_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_data   (cls_data),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_data  (scl_data)
    );

    // stage 5: raise/lower with clamps, doubles as the output register
    hwu_clamp u_clamp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (scl_valid),
        .in_ready    (scl_ready),
        .in_data     (scl_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .weight_out  (weight_out),
        .was_changed (m_tuser)
    );

    assign m_tdata = weight_out;

endmodule
